@@ hdl/bbl_pkg.sv @@
package bbl_pkg;

  localparam int BBL_CAPACITY = 16;

  // Operation codes carried in the op field of an input word.
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [3:0] position;
  } in_word_t;

  typedef struct packed {
    logic [4:0] count;
    logic [4:0] removed;
    logic [7:0] read_data;
    logic       ok;
  } out_word_t;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_APPEND  = 2'd1,
    CELL_SHIFT_R = 2'd2,
    CELL_COMPACT = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t  cmd;
    logic [7:0] value;
    logic       keep;
  } cell_ctl_t;

endpackage

@@ hdl/bbl_cell.sv @@
module bbl_cell #(
  parameter int CAPACITY = bbl_pkg::BBL_CAPACITY,
  parameter int IDX      = 0
) (
  input  logic                           clk,
  input  bbl_pkg::cell_ctl_t             ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]  cnt,
  input  logic [7:0]                     left_d,
  input  logic [7:0]                     right_d,
  input  logic [7:0]                     head_d,
  output logic [7:0]                     data_q
);
  import bbl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.cmd)
      CELL_HOLD: begin
        data_nxt = data_r;
      end
      CELL_APPEND: begin
        // Only the first free cell takes the new byte.
        if (CW'(IDX) == cnt) begin
          data_nxt = ctl.value;
        end
      end
      CELL_SHIFT_R: begin
        data_nxt = left_d;
      end
      CELL_COMPACT: begin
        // The window shifts toward the front; a kept head byte wraps to the
        // last occupied place of the window, which then does not shrink.
        if ((CW'(IDX + 1) == cnt) && ctl.keep) begin
          data_nxt = head_d;
        end else begin
          data_nxt = right_d;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

@@ hdl/bounded_byte_list_with_key_removal_core.sv @@
// Push back, push front, clear and read: the result word is registered in the cycle after the
// input word is accepted, and a new word can be accepted every cycle while the output drains.
// Remove: every held element walks past the head cell of the chain in turn, and the result
// word is registered once the walk is done; no input word is taken meanwhile.
// Reset (rst_n low, synchronous) empties the list and the output register; the cell bytes
// themselves are not reset and are only read after they were written.
module bounded_byte_list_with_key_removal_core #(
  parameter int CAPACITY = bbl_pkg::BBL_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbl_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output bbl_pkg::out_word_t  out_word
);
  import bbl_pkg::*;

  // Counter width: must hold CAPACITY itself.
  localparam int CW = $clog2(CAPACITY + 1);
  // Widened forms used to fit counts to the 5-bit output fields and to
  // compare the 4-bit position against the count.
  localparam int OW = (CW > 5) ? CW : 5;
  localparam int PW = (CW > 4) ? CW : 4;
  // Only the first sixteen cells can be addressed by a read.
  localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_COMPACT = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;      // elements held (window size while compacting)
  logic [CW-1:0] rem_r, rem_nxt;      // compaction steps still to do
  logic [CW-1:0] rmv_r, rmv_nxt;      // elements dropped by the running remove
  logic [7:0]    key_r, key_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic          in_fire;
  logic          out_busy;
  logic          full;
  logic          keep;
  logic [7:0]    rd_data;
  cell_ctl_t     cell_ctl;
  logic [7:0]    cell_q [CAPACITY];

  // The output register is held only while its word waits on a stalled receiver.
  assign out_busy = out_valid_r && out_stall;
  assign in_stall = (state_r != ST_IDLE) || out_busy;
  assign in_fire  = in_valid && !in_stall;
  assign full     = (cnt_r == CW'(CAPACITY));
  // The head cell decides whether its byte survives the current compaction step.
  assign keep     = (cell_q[0] != key_r);

  // Read port: the requested position picks one of the first sixteen cells.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (4'(i) == in_word.position) begin
        rd_data = cell_q[i];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    rmv_nxt       = rmv_r;
    key_nxt       = key_r;
    out_valid_nxt = out_busy;
    out_word_nxt  = out_word_r;
    cell_ctl.cmd   = CELL_HOLD;
    cell_ctl.value = in_word.value;
    cell_ctl.keep  = keep;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // Every operation except remove answers right away.
          out_valid_nxt          = 1'b1;
          out_word_nxt.removed   = '0;
          out_word_nxt.read_data = '0;
          out_word_nxt.ok        = 1'b0;
          priority if (in_word.op == OP_PUSH_BACK) begin
            if (!full) begin
              cell_ctl.cmd    = CELL_APPEND;
              cnt_nxt         = cnt_r + CW'(1);
              out_word_nxt.ok = 1'b1;
            end
          end else if (in_word.op == OP_PUSH_FRONT) begin
            if (!full) begin
              // Every byte moves one cell back; the new byte enters cell zero.
              cell_ctl.cmd    = CELL_SHIFT_R;
              cnt_nxt         = cnt_r + CW'(1);
              out_word_nxt.ok = 1'b1;
            end
          end else if (in_word.op == OP_REMOVE) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_COMPACT;
            rem_nxt       = cnt_r;
            rmv_nxt       = '0;
            key_nxt       = in_word.value;
          end else if (in_word.op == OP_CLEAR) begin
            cnt_nxt         = '0;
            out_word_nxt.ok = 1'b1;
          end else if (in_word.op == OP_READ) begin
            if (PW'(in_word.position) < PW'(cnt_r)) begin
              out_word_nxt.read_data = rd_data;
              out_word_nxt.ok        = 1'b1;
            end
          end else begin
            // Unused operation codes change nothing.
            out_word_nxt.ok = 1'b0;
          end
          out_word_nxt.count = 5'(OW'(cnt_nxt));
        end
      end
      ST_COMPACT: begin
        if (rem_r != '0) begin
          // One element passes the head cell per cycle.
          cell_ctl.cmd = CELL_COMPACT;
          rem_nxt      = rem_r - CW'(1);
          if (!keep) begin
            cnt_nxt = cnt_r - CW'(1);
            rmv_nxt = rmv_r + CW'(1);
          end
        end else if (!out_busy) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.count     = 5'(OW'(cnt_r));
          out_word_nxt.removed   = 5'(OW'(rmv_r));
          out_word_nxt.read_data = '0;
          out_word_nxt.ok        = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The chain: each cell sees its two neighbors and the head byte.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left_d;
    logic [7:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = in_word.value;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[0];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    bbl_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .cnt     (cnt_r),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (cell_q[0]),
      .data_q  (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      rmv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      rmv_r       <= rmv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The list never holds more than its capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  // Steps still to do never exceed the window they walk through.
  a_rem_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPACT) |-> (rem_r <= cnt_r))
    else $error("compaction steps exceed window");

  // A compaction step can only keep or shrink the list.
  a_compact_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPACT && rem_r != '0) |=> (cnt_r <= $past(cnt_r)))
    else $error("list grew during compaction");

endmodule

@@ sim/bounded_byte_list_with_key_removal_core_tb.sv @@
module bounded_byte_list_with_key_removal_core_tb;
  import bbl_pkg::*;

  // The list depth follows the package so the predictor and the block agree.
  localparam int LIST_DEPTH = BBL_CAPACITY;

  // Op codes 5 to 7 have no meaning; the block must answer them with ok low.
  localparam logic [2:0] OP_SPARE_LOW  = 3'd5;
  localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

  localparam int CLK_HALF         = 2;
  localparam int MAX_IDLE         = 16;
  // A remove walks every held element, so the drain wait scales with the depth
  // and leaves margin for anything still in flight once the last expected word has come back.
  localparam int DRAIN_CYCLES     = 2 * LIST_DEPTH + 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS     = 600;
  localparam int MAX_PRINTED      = 40;
  localparam int RUN_LIMIT_UNITS  = 2_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // Idle switches for the two sides; the random test turns them on and off
  // per phase so that there are stretches of back-to-back traffic too.
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;

  // A nonzero value asks the receiver to hold off for a long stretch, its length given by the value.
  int long_hold_request = 0;

  int error_count     = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int op_tally [8]    = '{default: 0};
  int full_refusals   = 0;
  int reads_past_end  = 0;
  int max_fill_seen   = 0;

  // Shadow copy of the list, kept as a circular store with a moving head.
  logic [7:0] list_bytes [LIST_DEPTH];
  int         list_head = 0;
  int         list_fill = 0;

  // Result words the list is expected to produce, oldest first.
  out_word_t expected_results [$];

  always #CLK_HALF clk = ~clk;

  bounded_byte_list_with_key_removal_core #(
    .CAPACITY(LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // Applies one operation to the shadow list and returns the word that the
  // block should answer with. Every operation yields exactly one word.
  function automatic out_word_t apply_list_op(input in_word_t w);
    out_word_t  res;
    int         r;
    int         kept;
    logic [7:0] elem;
    res = '0;
    case (w.op)
      OP_PUSH_BACK: begin
        if (list_fill < LIST_DEPTH) begin
          list_bytes[(list_head + list_fill) % LIST_DEPTH] = w.value;
          list_fill++;
          res.ok = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (list_fill < LIST_DEPTH) begin
          list_head = (list_head + LIST_DEPTH - 1) % LIST_DEPTH;
          list_bytes[list_head] = w.value;
          list_fill++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        // Survivors slide toward the front in their original order.
        kept = 0;
        for (r = 0; r < list_fill; r++) begin
          elem = list_bytes[(list_head + r) % LIST_DEPTH];
          if (elem != w.value) begin
            list_bytes[(list_head + kept) % LIST_DEPTH] = elem;
            kept++;
          end
        end
        res.removed = 5'(list_fill - kept);
        list_fill   = kept;
        res.ok      = 1'b1;
      end
      OP_CLEAR: begin
        list_fill = 0;
        list_head = 0;
        res.ok    = 1'b1;
      end
      OP_READ: begin
        if (int'(w.position) < list_fill) begin
          res.read_data = list_bytes[(list_head + int'(w.position)) % LIST_DEPTH];
          res.ok        = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.count = 5'(list_fill);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH %s", $time, what);
    end
  endtask

  // Every accepted input word is run through the shadow list right at the
  // edge that takes it, so the expectation order matches acceptance order.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      op_tally[in_word.op]++;
      if ((in_word.op == OP_PUSH_BACK || in_word.op == OP_PUSH_FRONT) &&
          list_fill == LIST_DEPTH) begin
        full_refusals++;
      end
      if (in_word.op == OP_READ && int'(in_word.position) >= list_fill) begin
        reads_past_end++;
      end
      expected_results.insert(expected_results.size(), apply_list_op(in_word));
      if (list_fill > max_fill_seen) begin
        max_fill_seen = list_fill;
      end
    end
  end

  // Every accepted result word is compared field by field with the oldest
  // expectation. A word that arrives with nothing pending is an error too.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", out_word));
      end else begin
        want = expected_results.pop_front();
        if (out_word.count !== want.count) begin
          report_mismatch($sformatf("count got %0d want %0d", out_word.count, want.count));
        end
        if (out_word.removed !== want.removed) begin
          report_mismatch($sformatf("removed got %0d want %0d",
                                    out_word.removed, want.removed));
        end
        if (out_word.read_data !== want.read_data) begin
          report_mismatch($sformatf("read_data got %h want %h",
                                    out_word.read_data, want.read_data));
        end
        if (out_word.ok !== want.ok) begin
          report_mismatch($sformatf("ok got %b want %b", out_word.ok, want.ok));
        end
      end
    end
  end

  // Receiver: before each result it may stall for a random number of cycles,
  // then it lowers stall and waits for a word. A long hold-off request from
  // a test takes priority and is counted out here, cycle by cycle. Valid is
  // sampled on the falling edge, where it is settled for the next rising one.
  initial begin : result_receiver
    int   wait_cycles;
    logic seen_valid;
    forever begin
      if (long_hold_request > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold_request) @(posedge clk);
        long_hold_request = 0;
      end else begin
        wait_cycles = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
        out_stall <= 1'b0;
        do begin
          @(negedge clk);
          seen_valid = out_valid;
          @(posedge clk);
        end while (!seen_valid && long_hold_request == 0);
      end
    end
  end

  // Offers one input word, after a random idle gap when idling is on, and
  // returns at the edge that accepts it. Valid stays high on return, so the
  // caller either sends the next word at once or lowers valid.
  task automatic send_word(input logic [2:0] op, input logic [7:0] value,
                           input logic [3:0] position);
    in_word_t w;
    int       gap;
    logic     stalled;
    w.op       = op;
    w.value    = value;
    w.position = position;
    gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    words_sent++;
  endtask

  // The sender stops offering until every word it sent has been answered.
  task automatic pause_until_drained();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (results_checked < words_sent) @(posedge clk);
  endtask

  // An empty list: reads at both position extremes are out of range, and a
  // remove finds nothing but still succeeds.
  task automatic test_empty_list();
    send_word(OP_READ, 8'h00, 4'd0);
    send_word(OP_READ, 8'hFF, 4'd15);
    send_word(OP_REMOVE, 8'h00, 4'd0);
    pause_until_drained();
  endtask

  // Fills the list from both ends, with the byte extremes and a repeated key
  // in it, then pushes once more at each end, which must be refused.
  task automatic test_fill_to_capacity();
    int         i;
    logic [7:0] v;
    for (i = 0; i < LIST_DEPTH; i++) begin
      if (i == 0) begin
        v = 8'h00;
      end else if (i == 1) begin
        v = 8'hFF;
      end else if (i % 3 == 0) begin
        v = 8'h5A;
      end else begin
        v = 8'(i * 17);
      end
      send_word((i % 2 == 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, v, 4'(i));
    end
    send_word(OP_PUSH_BACK, 8'h11, 4'd0);
    send_word(OP_PUSH_FRONT, 8'h22, 4'd15);
    send_word(OP_READ, 8'h00, 4'd15);
    send_word(OP_READ, 8'h00, 4'd0);
    pause_until_drained();
  endtask

  // A remove with no match leaves the list alone; the repeated key then goes
  // in one remove, and the old last position falls past the end.
  task automatic test_remove_and_read();
    send_word(OP_REMOVE, 8'h33, 4'd0);
    send_word(OP_REMOVE, 8'h5A, 4'd0);
    send_word(OP_READ, 8'h00, 4'd15);
    send_word(OP_READ, 8'h00, 4'd0);
    pause_until_drained();
  endtask

  // Unused op codes change nothing. After a clear the list is empty and the
  // front wraps cleanly when pushed from the front again.
  task automatic test_spare_ops_and_clear();
    send_word(OP_SPARE_LOW, 8'hFF, 4'd15);
    send_word(OP_SPARE_LOW + 3'd1, 8'h00, 4'd0);
    send_word(OP_SPARE_HIGH, 8'hA5, 4'd7);
    send_word(OP_CLEAR, 8'h00, 4'd0);
    send_word(OP_READ, 8'h00, 4'd0);
    send_word(OP_PUSH_FRONT, 8'hC3, 4'd0);
    send_word(OP_READ, 8'h00, 4'd0);
    pause_until_drained();
  endtask

  // The receiver holds off for a long time while the sender keeps offering
  // words back to back, so the block backs up and has to stall its input.
  task automatic test_output_backpressure();
    int         i;
    logic [2:0] op;
    send_idle_on      = 1'b0;
    long_hold_request = LONG_HOLD_CYCLES;
    for (i = 0; i < 24; i++) begin
      case ($urandom_range(0, 3))
        0:       op = OP_PUSH_BACK;
        1:       op = OP_PUSH_FRONT;
        2:       op = OP_READ;
        default: op = OP_REMOVE;
      endcase
      send_word(op, 8'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    end
    pause_until_drained();
    send_idle_on = 1'b1;
  endtask

  // Random phases: some lean toward pushing so the list often runs full,
  // others toward removing and reading. Values cluster around a key per phase
  // so removes usually hit several elements; reads mostly land in range.
  task automatic test_random_mix();
    int         remaining;
    int         phase_len;
    int         grow;
    int         roll;
    int         i;
    logic [7:0] key_base;
    logic [2:0] op;
    logic [7:0] value;
    logic [3:0] position;
    remaining = RANDOM_WORDS;
    while (remaining > 0) begin
      phase_len    = $urandom_range(20, 60);
      grow         = $urandom_range(0, 1);
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      key_base     = 8'($urandom_range(0, 255));
      for (i = 0; i < phase_len && remaining > 0; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < (grow ? 55 : 25)) begin
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else if (roll < (grow ? 70 : 50)) begin
          op = OP_REMOVE;
        end else if (roll < 95) begin
          op = OP_READ;
        end else if (roll < 98) begin
          op = OP_CLEAR;
        end else begin
          op = OP_SPARE_LOW + 3'($urandom_range(0, OP_SPARE_HIGH - OP_SPARE_LOW));
        end
        if ($urandom_range(0, 3) != 0) begin
          value = key_base + 8'($urandom_range(0, 3));
        end else begin
          value = 8'($urandom_range(0, 255));
        end
        if (list_fill > 0 && $urandom_range(0, 9) < 7) begin
          position = 4'($urandom_range(0, list_fill - 1));
        end else begin
          position = 4'($urandom_range(0, 15));
        end
        send_word(op, value, position);
        remaining--;
      end
      if ($urandom_range(0, 3) == 0) begin
        pause_until_drained();
      end
    end
    pause_until_drained();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  initial begin : test_sequence
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_fill_to_capacity();
    test_remove_and_read();
    test_spare_ops_and_clear();
    test_output_backpressure();
    test_random_mix();

    // Everything sent has been answered; give a stray extra word time to
    // show up before closing.
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", expected_results.size()));
    end

    $display("Ran %0d words: %0d push back, %0d push front, %0d remove, %0d clear,",
             words_sent, op_tally[OP_PUSH_BACK], op_tally[OP_PUSH_FRONT],
             op_tally[OP_REMOVE], op_tally[OP_CLEAR]);
    $display("%0d read, %0d unused op; pushes refused when full: %0d, reads past the end: %0d, largest fill: %0d.",
             op_tally[OP_READ], op_tally[5] + op_tally[6] + op_tally[7],
             full_refusals, reads_past_end, max_fill_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin : run_limit
    #(RUN_LIMIT_UNITS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
